[sv/btin_pkg.sv]
// btin_pkg: shared types and constants of the b+ tree internal node table
`timescale 1ns / 1ps
package btin_pkg;

    // default sizes of the node
    localparam int CAPACITY_DEF    = 64;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int CHILD_WIDTH_DEF = 32;

    // max_entries register
    localparam int              CFG_WIDTH         = 7;
    localparam logic [6:0]      MAX_ENTRIES_RESET = 7'd64;

    // result status field
    localparam int STATUS_WIDTH = 3;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_LOOKUP    = 2'd0,
        OP_INSERT    = 2'd1,
        OP_REM_CHILD = 2'd2,
        OP_REM_POS   = 2'd3
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_POS   = 3'd4
    } t_status;

    // per-cell update control
    typedef struct packed {
        logic load_new;  // store the new key and child
        logic shift_r;   // take the entry of the left neighbor
        logic shift_l;   // take the entry of the right neighbor
    } t_cell_ctl;

endpackage

[sv/btin_cell.sv]
// btin_cell: one entry of the node with its compare flags and shift path
`timescale 1ns / 1ps
module btin_cell
    import btin_pkg::*;
#(
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int CHILD_WIDTH = CHILD_WIDTH_DEF,
    parameter int CNT_W       = 7,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [KEY_WIDTH-1:0]   i_search_key,
    input  logic [CHILD_WIDTH-1:0] i_target_child,
    input  logic [KEY_WIDTH-1:0]   i_new_key,
    input  logic [CHILD_WIDTH-1:0] i_new_child,
    input  logic [KEY_WIDTH-1:0]   i_left_key,
    input  logic [CHILD_WIDTH-1:0] i_left_child,
    input  logic [KEY_WIDTH-1:0]   i_right_key,
    input  logic [CHILD_WIDTH-1:0] i_right_child,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [CHILD_WIDTH-1:0] o_child,
    output logic                   o_le,
    output logic                   o_cm
);

    logic [KEY_WIDTH-1:0]   r_key;
    logic [CHILD_WIDTH-1:0] r_child;
    logic                   r_le;
    logic                   r_cm;
    logic                   live;

    // entry is inside the filled part of the node
    assign live = CNT_W'(IDX) < i_count;

    // compare flags, registered every cycle
    always_ff @(posedge i_clk) begin
        if (IDX == 0) begin
            r_le <= live;
        end else begin
            r_le <= live && (r_key <= i_search_key);
        end
        r_cm <= live && (r_child == i_target_child);
    end

    // entry update: new value, shift right or shift left
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_key   <= i_new_key;
            r_child <= i_new_child;
        end else if (i_ctl.shift_r) begin
            r_key   <= i_left_key;
            r_child <= i_left_child;
        end else if (i_ctl.shift_l) begin
            r_key   <= i_right_key;
            r_child <= i_right_child;
        end
    end

    assign o_key   = r_key;
    assign o_child = r_child;
    assign o_le    = r_le;
    assign o_cm    = r_cm;

endmodule

[sv/btree_internal_node_table.sv]
// btree_internal_node_table: b+ tree internal node held in a row of entry cells
// result registered in S_APPLY once the output is free, after capture and the S_CMP compare
// items are taken one at a time, only in S_IDLE (capture, cell compare, cell update)
// every cell compares and shifts in parallel, so timing does not depend on the count
// reset: synchronous active low; clears count, state and output valid, max_entries to 64
// entry contents are not cleared by reset; only entries below the count are ever read
`timescale 1ns / 1ps
module btree_internal_node_table
    import btin_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int CHILD_WIDTH = CHILD_WIDTH_DEF,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int PW         = $clog2(CAPACITY),
    localparam int IN_W       = KEY_WIDTH + 2 * CHILD_WIDTH + PW,
    localparam int IN_TW      = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = CHILD_WIDTH + CNT_W + STATUS_WIDTH,
    localparam int OUT_TW     = ((OUT_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: max_entries
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_TW-1:0]     i_s_axis_tdata,  // search_key, target_child, new_child, position
    input  logic [1:0]           i_s_axis_tuser,  // opcode
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_TW-1:0]    o_m_axis_tdata   // child_out, entry_count, status
);

    localparam int LIM_W = (CNT_W > CFG_WIDTH) ? CNT_W : CFG_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    t_opcode                r_op;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [CHILD_WIDTH-1:0] r_target;
    logic [CHILD_WIDTH-1:0] r_newc;
    logic [PW-1:0]          r_pos;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CFG_WIDTH-1:0]   r_max;
    logic                   r_out_valid;
    logic [CHILD_WIDTH-1:0] r_out_child, n_out_child;
    logic [CNT_W-1:0]       r_out_count;
    t_status                r_out_status, n_out_status;

    logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
    logic [CHILD_WIDTH-1:0] cell_child [CAPACITY];
    t_cell_ctl              cell_ctl   [CAPACITY];
    logic [CAPACITY-1:0]    le_v;
    logic [CAPACITY-1:0]    cm_v;
    logic [CAPACITY-1:0]    pre_v;
    logic [CAPACITY-1:0]    sel_v;
    logic [CHILD_WIDTH-1:0] lk_child;
    logic                   in_fire;
    logic                   out_free;
    logic                   do_apply;
    logic                   found;
    logic                   full;
    logic                   pos_bad;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign do_apply = (r_state == S_APPLY) && out_free;

    // node conditions from the registered flags
    assign found   = |cm_v;
    assign full    = (LIM_W'(r_count) >= LIM_W'(r_max)) || (r_count >= CNT_W'(CAPACITY));
    assign pos_bad = CNT_W'(r_pos) >= r_count;

    // cells with their neighbor links and update control
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [KEY_WIDTH-1:0]   left_key, right_key;
        logic [CHILD_WIDTH-1:0] left_child, right_child;
        logic                   first_left;

        if (gi == 0) begin : g_first
            assign left_key   = '0;
            assign left_child = '0;
            assign first_left = 1'b0;
        end else begin : g_mid
            assign left_key   = cell_key[gi-1];
            assign left_child = cell_child[gi-1];
            assign first_left = cm_v[gi-1] && !pre_v[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign right_key   = '0;
            assign right_child = '0;
        end else begin : g_inner
            assign right_key   = cell_key[gi+1];
            assign right_child = cell_child[gi+1];
        end

        // match seen in a lower cell, and highest cell with a key at or below the search key
        assign pre_v[gi] = |(cm_v << (CAPACITY - gi));
        assign sel_v[gi] = le_v[gi] && !(|(le_v >> (gi + 1)));

        // update control for this cell
        always_comb begin
            cell_ctl[gi] = '0;
            if (do_apply) begin
                case (r_op)
                    OP_INSERT: begin
                        if (!full) begin
                            if (found) begin
                                cell_ctl[gi].load_new = first_left;
                                cell_ctl[gi].shift_r  = (gi != 0) && pre_v[(gi == 0) ? 0 : gi-1];
                            end else begin
                                cell_ctl[gi].load_new = (gi == 0);
                                cell_ctl[gi].shift_r  = (gi != 0);
                            end
                        end
                    end
                    OP_REM_CHILD: begin
                        cell_ctl[gi].shift_l = found && (pre_v[gi] || cm_v[gi]);
                    end
                    OP_REM_POS: begin
                        cell_ctl[gi].shift_l = !pos_bad && (PW'(gi) >= r_pos);
                    end
                    default: begin
                        cell_ctl[gi] = '0;
                    end
                endcase
            end
        end

        btin_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .CHILD_WIDTH (CHILD_WIDTH),
            .CNT_W       (CNT_W),
            .IDX         (gi)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (cell_ctl[gi]),
            .i_count        (r_count),
            .i_search_key   (r_key),
            .i_target_child (r_target),
            .i_new_key      (r_key),
            .i_new_child    (r_newc),
            .i_left_key     (left_key),
            .i_left_child   (left_child),
            .i_right_key    (right_key),
            .i_right_child  (right_child),
            .o_key          (cell_key[gi]),
            .o_child        (cell_child[gi]),
            .o_le           (le_v[gi]),
            .o_cm           (cm_v[gi])
        );
    end

    // lookup child: and-or over the selected cell
    always_comb begin
        lk_child = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            lk_child = lk_child | (cell_child[i] & {CHILD_WIDTH{sel_v[i]}});
        end
    end

    // result and new count
    always_comb begin
        n_count      = r_count;
        n_out_child  = '0;
        n_out_status = ST_OK;
        case (r_op)
            OP_LOOKUP: begin
                if (r_count == '0) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_out_child = lk_child;
                end
            end
            OP_INSERT: begin
                if (full) begin
                    n_out_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (!found) begin
                        n_out_status = ST_NOT_FOUND;
                    end
                end
            end
            OP_REM_CHILD: begin
                if (found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_out_status = ST_NOT_FOUND;
                end
            end
            OP_REM_POS: begin
                if (pos_bad) begin
                    n_out_status = ST_BAD_POS;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max       <= MAX_ENTRIES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (do_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured item and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= t_opcode'(i_s_axis_tuser);
            r_key    <= i_s_axis_tdata[KEY_WIDTH-1:0];
            r_target <= i_s_axis_tdata[KEY_WIDTH +: CHILD_WIDTH];
            r_newc   <= i_s_axis_tdata[KEY_WIDTH + CHILD_WIDTH +: CHILD_WIDTH];
            r_pos    <= i_s_axis_tdata[KEY_WIDTH + 2 * CHILD_WIDTH +: PW];
        end
        if (do_apply) begin
            r_out_child  <= n_out_child;
            r_out_count  <= n_count;
            r_out_status <= n_out_status;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TW'({r_out_status, r_out_count, r_out_child});

`ifndef SYNTHESIS
    // count never passes the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // lookup on a filled node selects exactly one cell
    a_lookup_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_op == OP_LOOKUP && r_count != '0) |-> $onehot(sel_v))
        else $error("lookup select not one-hot");

    // accepted insert grows the count by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_apply && r_op == OP_INSERT && !full) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the count");

    // a result is registered only after a compare cycle
    a_apply_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> ($past(r_state) == S_CMP || $past(r_state) == S_APPLY))
        else $error("update without compare cycle");
`endif

endmodule

[test/tb_top.sv]
// tb_top: self-checking testbench of the b+ tree internal node table
`timescale 1ns / 1ps
module tb_top;
    import btin_pkg::*;

    localparam int CAP            = 64;
    localparam int IN_TW          = 104;
    localparam int OUT_TW         = 48;
    localparam int LAT            = 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 150;
    localparam int RAND_ITEMS     = NUM_PHASES * PHASE_ITEMS;
    localparam int CALM_ITEMS     = 80;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 400;

    // one request to the node
    typedef struct {
        t_opcode     op;
        logic [31:0] key;
        logic [31:0] target;
        logic [31:0] new_child;
        logic [5:0]  pos;
    } t_node_req;

    // one response of the node
    typedef struct {
        logic [31:0] child;
        logic [6:0]  count;
        t_status     status;
    } t_node_rsp;

    // directed stimulus row: either a register write or a request
    typedef struct {
        bit        is_cfg;
        logic [6:0] cfg_val;
        t_node_req req;
        bit        typed;
        t_node_rsp rsp;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [6:0]        i_cfg_data;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_TW-1:0]  i_s_axis_tdata;   // search_key, target_child, new_child, position
    logic [1:0]        i_s_axis_tuser;   // opcode
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_TW-1:0] o_m_axis_tdata;   // child_out, entry_count, status

    // shadow copy of the node
    logic [31:0] node_key   [CAP];
    logic [31:0] node_child [CAP];
    int          node_count;
    logic [6:0]  node_limit;

    t_node_rsp pending_rsp_q [$];
    t_dir_row  dir_q [$];
    int        mismatches;
    int        rsp_seen;
    int        stall_cycles;
    bit        calm;
    bit        send_idle_on;
    bit        hold_done;
    t_node_rsp got_rsp;
    t_node_rsp exp_rsp;

    btree_internal_node_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // first entry holding a child, in the shadow node
    function automatic int find_slot(input logic [31:0] c, output bit hit);
        int i;
        hit = 1'b0;
        for (i = 0; i < node_count; i++) begin
            if (node_child[i] == c) begin
                hit = 1'b1;
                return i;
            end
        end
        return 0;
    endfunction

    // close the gap at a position
    function automatic void drop_entry(input int at);
        int i;
        for (i = at; i + 1 < node_count; i++) begin
            node_key[i]   = node_key[i + 1];
            node_child[i] = node_child[i + 1];
        end
        node_count--;
    endfunction

    // apply one request to the shadow node and return its response
    function automatic t_node_rsp apply_node_op(input t_node_req rq);
        t_node_rsp rs;
        int        at;
        int        i;
        int        lim;
        bit        hit;
        rs.child  = '0;
        rs.status = ST_OK;
        lim = (int'(node_limit) < CAP) ? int'(node_limit) : CAP;
        case (rq.op)
            OP_LOOKUP: begin
                if (node_count == 0) begin
                    rs.status = ST_EMPTY;
                end else begin
                    at = 0;
                    for (i = 1; i < node_count; i++)
                        if (node_key[i] <= rq.key) at = i;
                    rs.child = node_child[at];
                end
            end
            OP_INSERT: begin
                if (node_count >= lim) begin
                    rs.status = ST_FULL;
                end else begin
                    at = find_slot(rq.target, hit);
                    if (hit) at = at + 1;
                    else rs.status = ST_NOT_FOUND;
                    for (i = node_count; i > at; i--) begin
                        node_key[i]   = node_key[i - 1];
                        node_child[i] = node_child[i - 1];
                    end
                    node_key[at]   = rq.key;
                    node_child[at] = rq.new_child;
                    node_count++;
                end
            end
            OP_REM_CHILD: begin
                at = find_slot(rq.target, hit);
                if (hit) drop_entry(at);
                else rs.status = ST_NOT_FOUND;
            end
            default: begin
                if (int'(rq.pos) >= node_count) rs.status = ST_BAD_POS;
                else drop_entry(int'(rq.pos));
            end
        endcase
        rs.count = 7'(node_count);
        return rs;
    endfunction

    // random request, mostly aimed at entries the node holds
    function automatic t_node_req gen_node_req(input int ins_pct);
        t_node_req rq;
        int        sel;
        logic [31:0] k;
        sel = $urandom_range(0, 99);
        if (sel < ins_pct) begin
            rq.op = OP_INSERT;
        end else begin
            sel = $urandom_range(0, 9);
            if (sel < 4) rq.op = OP_LOOKUP;
            else if (sel < 7) rq.op = OP_REM_CHILD;
            else rq.op = OP_REM_POS;
        end
        // key: random, small, extreme or near a stored key
        case ($urandom_range(0, 7))
            0, 1: k = $urandom;
            2, 3: k = $urandom_range(0, 15);
            4: k = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: begin
                if (node_count > 1) begin
                    k = node_key[$urandom_range(1, node_count - 1)];
                    case ($urandom_range(0, 2))
                        0: k = k + 32'd1;
                        1: k = k - 32'd1;
                        default: ;
                    endcase
                end else begin
                    k = $urandom;
                end
            end
        endcase
        rq.key = k;
        // target child: mostly one that is present
        if (node_count > 0 && $urandom_range(0, 99) < 85)
            rq.target = node_child[$urandom_range(0, node_count - 1)];
        else
            rq.target = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 31));
        // new child: a small range brings duplicates
        rq.new_child = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 31)) : $urandom;
        // position: mostly inside the count
        if (node_count > 0 && $urandom_range(0, 99) < 80)
            rq.pos = 6'($urandom_range(0, node_count - 1));
        else
            rq.pos = 6'($urandom_range(0, 63));
        return rq;
    endfunction

    // offer one request and queue its response once it is taken
    task automatic send_req(input t_node_req rq, input bit typed, input t_node_rsp typed_rsp);
        t_node_rsp rs;
        if (!calm && send_idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, rq.pos, rq.new_child, rq.target, rq.key};
        i_s_axis_tuser  <= rq.op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rs = apply_node_op(rq);
        if (typed) pending_rsp_q.push_back(typed_rsp);
        else pending_rsp_q.push_back(rs);
    endtask

    // write max_entries once the node is idle
    task automatic write_max_entries(input logic [6:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        node_limit = val;
    endtask

    // directed table entry
    task automatic add_row(input bit is_cfg, input logic [6:0] cfg_val, input t_opcode op,
                           input logic [31:0] key, input logic [31:0] target,
                           input logic [31:0] new_child, input logic [5:0] pos,
                           input bit typed, input logic [31:0] e_child,
                           input logic [6:0] e_count, input t_status e_status);
        t_dir_row row;
        row.is_cfg        = is_cfg;
        row.cfg_val       = cfg_val;
        row.req.op        = op;
        row.req.key       = key;
        row.req.target    = target;
        row.req.new_child = new_child;
        row.req.pos       = pos;
        row.typed         = typed;
        row.rsp.child     = e_child;
        row.rsp.count     = e_count;
        row.rsp.status    = e_status;
        dir_q.push_back(row);
    endtask

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            rsp_seen++;
            got_rsp.child  = o_m_axis_tdata[31:0];
            got_rsp.count  = o_m_axis_tdata[38:32];
            got_rsp.status = t_status'(o_m_axis_tdata[41:39]);
            if (pending_rsp_q.size() == 0) begin
                $error("unexpected result transaction: data %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                exp_rsp = pending_rsp_q.pop_front();
                if (got_rsp.child !== exp_rsp.child) begin
                    $error("child_out: expected %h, actual %h", exp_rsp.child, got_rsp.child);
                    mismatches++;
                end
                if (got_rsp.count !== exp_rsp.count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           exp_rsp.count, got_rsp.count);
                    mismatches++;
                end
                if (got_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d",
                           exp_rsp.status, got_rsp.status);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("btree_internal_node_table test failed");
            $finish;
        end
    end

    // result side ready: random bursts, quiet stretches and one long hold
    initial begin
        i_m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!calm && !hold_done && rsp_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && ((rsp_seen / 100) % 3 != 1) && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // main sequence
    initial begin
        logic [6:0] phase_cfg [NUM_PHASES];
        int         phase_ins [NUM_PHASES];
        t_dir_row   row;
        t_node_req  rq;
        t_node_rsp  none_rsp;
        int         ph;
        int         n;
        int         sent;

        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_LOOKUP;
        mismatches   = 0;
        rsp_seen     = 0;
        stall_cycles = 0;
        calm         = 1'b0;
        hold_done    = 1'b0;
        send_idle_on = 1'b1;
        node_count   = 0;
        node_limit   = MAX_ENTRIES_RESET;
        none_rsp.child  = '0;
        none_rsp.count  = '0;
        none_rsp.status = ST_OK;

        // directed rows: empty node, extremes, absent child, bad position, full node
        add_row(1'b0, 7'd0, OP_LOOKUP,    32'h0,         32'h0,         32'h0,         6'd0,
                1'b1, 32'h0, 7'd0, ST_EMPTY);
        add_row(1'b0, 7'd0, OP_REM_CHILD, 32'h0,         32'h0,         32'h0,         6'd0,
                1'b1, 32'h0, 7'd0, ST_NOT_FOUND);
        add_row(1'b0, 7'd0, OP_REM_POS,   32'h0,         32'h0,         32'h0,         6'd0,
                1'b1, 32'h0, 7'd0, ST_BAD_POS);
        add_row(1'b0, 7'd0, OP_INSERT,    32'hFFFF_FFFF, 32'h0000_0005, 32'hFFFF_FFFF, 6'd0,
                1'b1, 32'h0, 7'd1, ST_NOT_FOUND);
        add_row(1'b0, 7'd0, OP_INSERT,    32'h0,         32'hFFFF_FFFF, 32'h0,         6'd0,
                1'b1, 32'h0, 7'd2, ST_OK);
        add_row(1'b0, 7'd0, OP_INSERT,    32'h8000_0000, 32'h0,         32'h1234_5678, 6'd0,
                1'b1, 32'h0, 7'd3, ST_OK);
        add_row(1'b0, 7'd0, OP_LOOKUP,    32'h0,         32'h0,         32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_LOOKUP,    32'hFFFF_FFFF, 32'h0,         32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_LOOKUP,    32'h7FFF_FFFF, 32'h0,         32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_INSERT,    32'h5555_AAAA, 32'h0000_DEAD, 32'hAAAA_5555, 6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_REM_POS,   32'h0,         32'h0,         32'h0,         6'd63,
                1'b1, 32'h0, 7'd4, ST_BAD_POS);
        add_row(1'b0, 7'd0, OP_REM_POS,   32'h0,         32'h0,         32'h0,         6'd3,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_REM_CHILD, 32'h0,         32'h0,         32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_REM_CHILD, 32'h0,         32'h0000_CAFE, 32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b1, 7'd2, OP_LOOKUP,    32'h0,         32'h0,         32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_INSERT,    32'h0000_0010, 32'hFFFF_FFFF, 32'h0000_0077, 6'd0,
                1'b1, 32'h0, 7'd2, ST_FULL);
        add_row(1'b0, 7'd0, OP_REM_POS,   32'h0,         32'h0,         32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_INSERT,    32'h0000_0020, 32'h0BAD_0BAD, 32'h0000_0099, 6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);
        add_row(1'b0, 7'd0, OP_LOOKUP,    32'h0,         32'h0,         32'h0,         6'd0,
                1'b0, 32'h0, 7'd0, ST_OK);

        // random phases: limit and share of inserts
        phase_cfg[0] = 7'd64;                       phase_ins[0] = 75;
        phase_cfg[1] = 7'd2;                        phase_ins[1] = 20;
        phase_cfg[2] = 7'd33;                       phase_ins[2] = 50;
        phase_cfg[3] = 7'($urandom_range(2, 64));   phase_ins[3] = 55;
        phase_cfg[4] = 7'd64;                       phase_ins[4] = 70;
        phase_cfg[5] = 7'd5;                        phase_ins[5] = 40;
        phase_cfg[6] = 7'($urandom_range(2, 64));   phase_ins[6] = 45;

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_q[d]) begin
            row = dir_q[d];
            if (row.is_cfg) write_max_entries(row.cfg_val);
            else send_req(row.req, row.typed, row.rsp);
        end

        // random part
        sent = 0;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_max_entries(phase_cfg[ph]);
            send_idle_on = (ph != 2);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                calm = (sent >= RAND_ITEMS - CALM_ITEMS);
                rq = gen_node_req(phase_ins[ph]);
                send_req(rq, 1'b0, none_rsp);
                sent++;
            end
        end

        // drain
        i_s_axis_tvalid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (LAT * 4) @(posedge i_clk);
        if (mismatches == 0 && pending_rsp_q.size() == 0) begin
            $display("btree_internal_node_table test passed");
        end else begin
            $display("btree_internal_node_table test failed");
        end
        $finish;
    end

endmodule
